// ----- rtl/core/osek_pkg.sv -----
package osek_pkg;

	localparam int WORD_W          = 64;
	localparam int KIND_W          = 4;
	localparam int ERR_W           = 2;
	localparam int COUNT_W         = 7;
	localparam int STACK_DEPTH_DEF = 64;

	typedef enum logic [KIND_W-1:0] {
		K_PUSH  = 4'd0,
		K_DROP  = 4'd1,
		K_DROPN = 4'd2,
		K_SWAP  = 4'd3,
		K_DUP   = 4'd4,
		K_PICK  = 4'd5,
		K_ROLL  = 4'd6,
		K_ROLLD = 4'd7,
		K_CLEAR = 4'd8,
		K_DEPTH = 4'd9
	} kind_t;

	typedef enum logic [ERR_W-1:0] {
		E_OK    = 2'd0,
		E_UNDER = 2'd1,
		E_OVER  = 2'd2
	} err_t;

	// per-cycle command broadcast to every cell
	typedef enum logic [2:0] {
		OP_HOLD    = 3'd0,
		OP_PUSH    = 3'd1,
		OP_POP     = 3'd2,
		OP_SWAP    = 3'd3,
		OP_CLOAD   = 3'd4,
		OP_CSHIFT  = 3'd5,
		OP_TOPLOAD = 3'd6
	} cell_op_t;

endpackage

// ----- rtl/core/osek_if.sv -----
interface osek_cmd_if import osek_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic signed [WORD_W-1:0] push_value;

	modport source (output valid, kind, push_value, input ready);
	modport sink (input valid, kind, push_value, output ready);
endinterface

interface osek_rsp_if import osek_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [ERR_W-1:0]         error_code;
	logic [COUNT_W-1:0]       entry_count;
	logic signed [WORD_W-1:0] top_word;
	logic                     top_valid;

	modport source (output valid, error_code, entry_count, top_word, top_valid, input ready);
	modport sink (input valid, error_code, entry_count, top_word, top_valid, output ready);
endinterface

// ----- rtl/core/operand_stack_engine_unit.sv -----
// channel | dir | payload
// cmd     | in  | kind, push_value
// rsp     | out | error_code, entry_count, top_word, top_valid
//
// Push, drop, swap, dup, clear, depth, failed and unused commands go straight to
// the done state; dropn n, pick L and roll/rolld L pass through a run state whose
// stay grows with n or L, as words move one cell per cycle along the cell chain.
// Reset clears the count and control; cell words are not reset.
// A result waits in the output register while the next command is accepted.
module operand_stack_engine_unit import osek_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	osek_cmd_if.sink  cmd,
	osek_rsp_if.source rsp
);

	localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t            state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [IW-1:0]     rem_q, rem_d;
	logic [IW-1:0]     lvl_q, lvl_d;
	kind_t             kind_q, kind_d;
	err_t              err_q, err_d;

	cell_op_t          op;
	logic [IW-1:0]     k;
	logic [WORD_W-1:0] pv;

	logic [WORD_W-1:0] words [STACK_DEPTH];
	logic [WORD_W-1:0] carries [STACK_DEPTH];

	logic              rsp_valid_q;
	logic [ERR_W-1:0]  rsp_err_q;
	logic [COUNT_W-1:0] rsp_count_q;
	logic [WORD_W-1:0] rsp_top_q;
	logic              rsp_topv_q;

	logic [WORD_W-1:0] t;
	logic [CW-1:0]     t_cw;
	logic [CW-1:0]     cm1;
	logic              t_small, lvl_ok, dropn_ok, full, empty, out_free;

	genvar gi;
	generate
		for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
			logic [WORD_W-1:0] dn, up, cu;
			if (gi == 0) begin : g_first
				assign dn = pv;
			end else begin : g_mid
				assign dn = words[gi-1];
			end
			if (gi == STACK_DEPTH - 1) begin : g_last
				assign up = '0;
				assign cu = '0;
			end else begin : g_inner
				assign up = words[gi+1];
				assign cu = carries[gi+1];
			end
			osek_cell #(.IDX_W(IW), .IDX(gi)) u_cell (
				.clk      (clk),
				.op       (op),
				.k        (k),
				.word_dn  (dn),
				.word_up  (up),
				.carry_up (cu),
				.word     (words[gi]),
				.carry    (carries[gi])
			);
		end
	endgenerate

	assign t        = words[0];
	assign t_cw     = t[CW-1:0];
	assign t_small  = (t[WORD_W-1:CW] == '0);
	assign empty    = (count_q == '0);
	assign cm1      = count_q - 1'b1;
	assign lvl_ok   = !empty && t_small && (t_cw < cm1);
	assign dropn_ok = !empty && t_small && (t_cw <= cm1);
	assign full     = (count_q == CW'(STACK_DEPTH));
	assign out_free = !rsp_valid_q || rsp.ready;

	assign cmd.ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		rem_d   = rem_q;
		lvl_d   = lvl_q;
		kind_d  = kind_q;
		err_d   = err_q;
		op      = OP_HOLD;
		k       = '0;
		pv      = cmd.push_value;
		case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					kind_d  = kind_t'(cmd.kind);
					err_d   = E_OK;
					state_d = S_DONE;
					case (kind_t'(cmd.kind))
						K_PUSH: begin
							if (full) err_d = E_OVER;
							else begin
								op = OP_PUSH;
								count_d = count_q + 1'b1;
							end
						end
						K_DROP: begin
							if (empty) err_d = E_UNDER;
							else begin
								op = OP_POP;
								count_d = cm1;
							end
						end
						K_DROPN: begin
							if (!dropn_ok) err_d = E_UNDER;
							else begin
								op = OP_POP;
								count_d = cm1 - t_cw;
								rem_d = IW'(t_cw);
								state_d = S_RUN;
							end
						end
						K_SWAP: begin
							if (count_q < CW'(2)) err_d = E_UNDER;
							else op = OP_SWAP;
						end
						K_DUP: begin
							if (empty) err_d = E_UNDER;
							else if (full) err_d = E_OVER;
							else begin
								op = OP_PUSH;
								pv = t;
								count_d = count_q + 1'b1;
							end
						end
						K_PICK: begin
							if (!lvl_ok) err_d = E_UNDER;
							else begin
								op = OP_CLOAD;
								k = IW'(t_cw + 1'b1);
								rem_d = IW'(t_cw + 1'b1);
								state_d = S_RUN;
							end
						end
						K_ROLL, K_ROLLD: begin
							if (!lvl_ok) err_d = E_UNDER;
							else begin
								op = OP_POP;
								count_d = cm1;
								rem_d = IW'(t_cw);
								lvl_d = IW'(t_cw);
								state_d = S_RUN;
							end
						end
						K_CLEAR: count_d = '0;
						K_DEPTH: begin
							if (full) err_d = E_OVER;
							else begin
								op = OP_PUSH;
								pv = WORD_W'(count_q);
								count_d = count_q + 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_RUN: begin
				case (kind_q)
					K_DROPN: begin
						if (rem_q != '0) begin
							op = OP_POP;
							rem_d = rem_q - 1'b1;
						end else state_d = S_DONE;
					end
					K_PICK: begin
						if (rem_q != '0) begin
							op = OP_CSHIFT;
							rem_d = rem_q - 1'b1;
						end else begin
							op = OP_TOPLOAD;
							state_d = S_DONE;
						end
					end
					K_ROLL: begin
						if (rem_q != '0) begin
							op = OP_SWAP;
							k = rem_q - 1'b1;
							rem_d = rem_q - 1'b1;
						end else state_d = S_DONE;
					end
					K_ROLLD: begin
						if (rem_q != '0) begin
							op = OP_SWAP;
							k = lvl_q - rem_q;
							rem_d = rem_q - 1'b1;
						end else state_d = S_DONE;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			lvl_q       <= '0;
			kind_q      <= K_CLEAR;
			err_q       <= E_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			lvl_q   <= lvl_d;
			kind_q  <= kind_d;
			err_q   <= err_d;
			if (state_q == S_DONE && out_free) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp_err_q   <= err_q;
			rsp_count_q <= COUNT_W'(count_q);
			rsp_top_q   <= empty ? '0 : words[0];
			rsp_topv_q  <= !empty;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.error_code  = rsp_err_q;
	assign rsp.entry_count = rsp_count_q;
	assign rsp.top_word    = rsp_top_q;
	assign rsp.top_valid   = rsp_topv_q;

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH)) else $error("stack count above depth");

	a_run_kind: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |-> (kind_q == K_DROPN || kind_q == K_PICK ||
			kind_q == K_ROLL || kind_q == K_ROLLD))
		else $error("multi-cycle sequence on single-cycle command");

	a_err_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && cmd.valid && err_d != E_OK |=> $stable(count_q))
		else $error("failed command changed the count");
`endif

endmodule

// ----- rtl/core/osek_cell.sv -----
module osek_cell import osek_pkg::*; #(
	parameter int IDX_W = 6,
	parameter int IDX   = 0
) (
	input  logic              clk,
	input  cell_op_t          op,
	input  logic [IDX_W-1:0]  k,
	input  logic [WORD_W-1:0] word_dn,
	input  logic [WORD_W-1:0] word_up,
	input  logic [WORD_W-1:0] carry_up,
	output logic [WORD_W-1:0] word,
	output logic [WORD_W-1:0] carry
);

	localparam logic [IDX_W:0] MY = (IDX_W+1)'(IDX);

	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] carry_q;
	logic              at_k;
	logic              at_k1;

	assign at_k  = (MY == {1'b0, k});
	assign at_k1 = (MY == (IDX_W+1)'({1'b0, k} + 1'b1));

	always_ff @(posedge clk) begin
		case (op)
			OP_PUSH: word_q <= word_dn;
			OP_POP: word_q <= word_up;
			OP_SWAP: begin
				if (at_k) word_q <= word_up;
				else if (at_k1) word_q <= word_dn;
			end
			OP_CLOAD: begin
				if (at_k) carry_q <= word_q;
			end
			OP_CSHIFT: carry_q <= carry_up;
			OP_TOPLOAD: begin
				if (IDX == 0) word_q <= carry_q;
			end
			default: ;
		endcase
	end

	assign word  = word_q;
	assign carry = carry_q;

endmodule
